/* hw/rtl/rpgt_pkg.sv */
package rpgt_pkg;

  // Coordinate and payload widths
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned POINT_W    = 13;
  localparam int unsigned RECT_W     = 48;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned COUNT_W    = 3;

  // Occupancy tag width; the tag memory is swept when the tag wraps
  localparam int unsigned EPOCH_W = 8;

  // Parameter defaults
  localparam int unsigned DEF_GRID_COLUMNS     = 16;
  localparam int unsigned DEF_GRID_ROWS        = 16;
  localparam int unsigned DEF_MAX_IGNORE_RECTS = 4;

  // Register values after reset
  localparam logic [COORD_W-1:0] RESET_FRAME_WIDTH  = 12'd640;
  localparam logic [COORD_W-1:0] RESET_FRAME_HEIGHT = 12'd480;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_BORDER   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_COUNT  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_RECT_0 = 8'd4;

endpackage

/* hw/rtl/rpgt_divider.sv */
module rpgt_divider #(
  parameter int unsigned QUOT_W = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [rpgt_pkg::COORD_W+QUOT_W-1:0]  dividend_i,
  input  logic [rpgt_pkg::COORD_W-1:0]         divisor_i,
  output logic                                 done_o,
  output logic [QUOT_W-1:0]                    quotient_o
);
  import rpgt_pkg::*;

  localparam int unsigned DIV_W = COORD_W + QUOT_W;
  localparam int unsigned CNT_W = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;

  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  dsr_q, dsr_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [QUOT_W:0]   quot_w;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              ge;

  // Restoring division, one quotient bit a cycle, most significant first.
  // The caller guarantees dividend < divisor << QUOT_W.
  assign ge     = (rem_q >= dsr_q);
  assign quot_w = {quot_q, ge};

  always_comb begin
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dsr_d  = DIV_W'(divisor_i) << (QUOT_W - 1);
      quot_d = '0;
      cnt_d  = CNT_W'(QUOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? (rem_q - dsr_q) : rem_q;
      dsr_d  = dsr_q >> 1;
      quot_d = quot_w[QUOT_W-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

/* hw/rtl/road_point_grid_thinning_unit.sv */
// Road point grid thinning.
// Points come in on the valid/ready input channel, one word per point; each
// produces exactly one result word on the output channel with keep set or
// clear and the coordinates and frame_end passed through. A point is dropped
// when the frame size is zero, it lies outside the frame, in an enabled
// ignore rectangle, or on the border with border dropping on; otherwise it is
// kept only if it is the first of its frame in its grid cell.
// A point that reaches the grid goes from acceptance through the states LDX,
// DIVX, LDY, DIVY, READ, CHECK and EMIT to the result register, the one
// shared bit-serial divider working out the column, then the row. A point
// dropped early goes straight to EMIT. One point is in flight at a time, so
// no new point is taken until the last one's result is loaded out.
// The output register lets the next point be accepted while a result waits;
// a stalled receiver holds the finished point until the register frees up.
// Cell occupancy is kept as a frame tag per cell; after reset, and once every
// 255 frame starts when the tag wraps, the tag memory is swept, one cell a
// cycle, with the input not ready.
// Configuration writes are always accepted; send them only with no point in
// flight.
module road_point_grid_thinning_unit #(
  parameter int unsigned GRID_COLUMNS     = rpgt_pkg::DEF_GRID_COLUMNS,
  parameter int unsigned GRID_ROWS        = rpgt_pkg::DEF_GRID_ROWS,
  parameter int unsigned MAX_IGNORE_RECTS = rpgt_pkg::DEF_MAX_IGNORE_RECTS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [rpgt_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [rpgt_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // Points in
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [rpgt_pkg::POINT_W-1:0]    point_x_i,
  input  logic signed [rpgt_pkg::POINT_W-1:0]    point_y_i,
  input  logic                                   frame_start_i,
  input  logic                                   frame_end_i,
  // Results out
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   keep_o,
  output logic signed [rpgt_pkg::POINT_W-1:0]    out_x_o,
  output logic signed [rpgt_pkg::POINT_W-1:0]    out_y_o,
  output logic                                   out_frame_end_o
);
  import rpgt_pkg::*;

  localparam int unsigned COL_W   = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int unsigned ROW_W   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int unsigned QUOT_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned DIV_W   = COORD_W + QUOT_W;
  localparam int unsigned CELLS   = GRID_COLUMNS * GRID_ROWS;
  localparam int unsigned CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned CSUM_W  = CELL_W + COL_W + 1;

  localparam logic [CELL_W-1:0]  LAST_CELL = CELL_W'(CELLS - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

  // Sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LDX   = 4'd2;
  localparam logic [3:0] S_DIVX  = 4'd3;
  localparam logic [3:0] S_LDY   = 4'd4;
  localparam logic [3:0] S_DIVY  = 4'd5;
  localparam logic [3:0] S_READ  = 4'd6;
  localparam logic [3:0] S_CHECK = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  // Configuration registers
  logic [COORD_W-1:0] frame_width_q, frame_height_q;
  logic               drop_border_q;
  logic [COUNT_W-1:0] ignore_count_q;
  logic [RECT_W-1:0]  rect_q [MAX_IGNORE_RECTS];
  logic               cfg_fire;

  // Sequencer and point registers
  logic [3:0]                state_q, state_d;
  logic [EPOCH_W-1:0]        epoch_q, epoch_d;
  logic [CELL_W-1:0]         clr_q, clr_d;
  logic                      pending_q, pending_d;
  logic                      drop_q;
  logic                      keep_q;
  logic signed [POINT_W-1:0] x_q, y_q;
  logic                      fe_q;
  logic [COL_W-1:0]          col_q;
  logic [ROW_W-1:0]          row_q;

  // Output register
  logic                      out_valid_q;
  logic                      out_keep_q;
  logic signed [POINT_W-1:0] out_x_q, out_y_q;
  logic                      out_fe_q;
  logic                      out_load;

  // Early drop checks
  logic [COORD_W-1:0]          px, py;
  logic                        neg, zero_size, outside, border, rect_hit, drop;
  logic [MAX_IGNORE_RECTS-1:0] rect_in;
  logic                        in_fire;
  logic                        wrap;

  // Divider
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dividend;
  logic [COORD_W-1:0] div_divisor;
  logic [QUOT_W-1:0] div_quot;
  logic [COL_W-1:0]  col_clamped;
  logic [ROW_W-1:0]  row_clamped;

  // Tag memory
  logic [EPOCH_W-1:0] tag_mem [CELLS];
  logic [EPOCH_W-1:0] rd_q;
  logic [CSUM_W-1:0]  cell_sum;
  logic [CELL_W-1:0]  cell_idx;
  logic               taken;
  logic               mem_we;
  logic [CELL_W-1:0]  mem_waddr;
  logic [EPOCH_W-1:0] mem_wdata;

  // ---------------------------------------------------------------------
  // Configuration port, always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RESET_FRAME_WIDTH;
      frame_height_q <= RESET_FRAME_HEIGHT;
      drop_border_q  <= 1'b0;
      ignore_count_q <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[COORD_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[COORD_W-1:0];
        REG_DROP_BORDER:  drop_border_q  <= cfg_data_i[0];
        REG_IGNORE_COUNT: ignore_count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Rectangles beyond MAX_IGNORE_RECTS are never used, so not stored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_IGNORE_RECTS; i++) begin
        rect_q[i] <= '0;
      end
    end else if (cfg_fire) begin
      for (int i = 0; i < MAX_IGNORE_RECTS; i++) begin
        if (cfg_index_i == REG_IGNORE_RECT_0 + CFG_IDX_W'(i)) begin
          rect_q[i] <= cfg_data_i[RECT_W-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drop checks on the incoming word
  assign px        = point_x_i[COORD_W-1:0];
  assign py        = point_y_i[COORD_W-1:0];
  assign neg       = point_x_i[POINT_W-1] | point_y_i[POINT_W-1];
  assign zero_size = (frame_width_q == '0) | (frame_height_q == '0);
  assign outside   = (px >= frame_width_q) | (py >= frame_height_q);
  assign border    = drop_border_q &
                     ((px == '0) | (py == '0) |
                      (px == frame_width_q - 1'b1) | (py == frame_height_q - 1'b1));

  // Inverted rectangles cover nothing by the same compares
  always_comb begin
    for (int i = 0; i < MAX_IGNORE_RECTS; i++) begin
      rect_in[i] = (ignore_count_q > COUNT_W'(i)) &
                   (px >= rect_q[i][11:0])  & (px <= rect_q[i][23:12]) &
                   (py >= rect_q[i][35:24]) & (py <= rect_q[i][47:36]);
    end
  end

  assign rect_hit = |rect_in;
  assign drop     = zero_size | neg | outside | rect_hit | border;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign wrap       = frame_start_i & (epoch_q == EPOCH_MAX);

  // ---------------------------------------------------------------------
  // Shared divider: column first, then row
  assign div_start    = (state_q == S_LDX) | (state_q == S_LDY);
  assign div_dividend = (state_q == S_LDX) ?
                        DIV_W'(x_q[COORD_W-1:0]) * DIV_W'(GRID_COLUMNS) :
                        DIV_W'(y_q[COORD_W-1:0]) * DIV_W'(GRID_ROWS);
  assign div_divisor  = (state_q == S_LDX) ? frame_width_q : frame_height_q;

  rpgt_divider #(
    .QUOT_W (QUOT_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign col_clamped = (div_quot > QUOT_W'(GRID_COLUMNS - 1)) ?
                       COL_W'(GRID_COLUMNS - 1) : div_quot[COL_W-1:0];
  assign row_clamped = (div_quot > QUOT_W'(GRID_ROWS - 1)) ?
                       ROW_W'(GRID_ROWS - 1) : div_quot[ROW_W-1:0];

  // ---------------------------------------------------------------------
  // Cell lookup: a cell is taken when its tag equals the current frame tag
  assign cell_sum = CSUM_W'(row_q) * CSUM_W'(GRID_COLUMNS) + CSUM_W'(col_q);
  assign cell_idx = cell_sum[CELL_W-1:0];
  assign taken    = (rd_q == epoch_q);

  assign mem_we    = (state_q == S_CLEAR) | ((state_q == S_CHECK) & !taken);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_q : cell_idx;
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : epoch_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= mem_wdata;
    end
    if (state_q == S_READ) begin
      rd_q <= tag_mem[cell_idx];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  assign out_load = (state_q == S_EMIT) & (!out_valid_q | out_ready_i);

  always_comb begin
    state_d   = state_q;
    epoch_d   = epoch_q;
    clr_d     = clr_q;
    pending_d = pending_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_CELL) begin
          clr_d     = '0;
          pending_d = 1'b0;
          if (!pending_q) begin
            state_d = S_IDLE;
          end else if (drop_q) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_LDX;
          end
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (wrap) begin
            epoch_d   = EPOCH_ONE;
            pending_d = 1'b1;
            state_d   = S_CLEAR;
          end else begin
            if (frame_start_i) begin
              epoch_d = epoch_q + 1'b1;
            end
            state_d = drop ? S_EMIT : S_LDX;
          end
        end
      end
      S_LDX:   state_d = S_DIVX;
      S_DIVX:  if (div_done) state_d = S_LDY;
      S_LDY:   state_d = S_DIVY;
      S_DIVY:  if (div_done) state_d = S_READ;
      S_READ:  state_d = S_CHECK;
      S_CHECK: state_d = S_EMIT;
      S_EMIT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      epoch_q   <= EPOCH_ONE;
      clr_q     <= '0;
      pending_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      epoch_q   <= epoch_d;
      clr_q     <= clr_d;
      pending_q <= pending_d;
    end
  end

  // Point registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q    <= point_x_i;
      y_q    <= point_y_i;
      fe_q   <= frame_end_i;
      drop_q <= drop;
      keep_q <= 1'b0;
    end
    if ((state_q == S_DIVX) && div_done) begin
      col_q <= col_clamped;
    end
    if ((state_q == S_DIVY) && div_done) begin
      row_q <= row_clamped;
    end
    if (state_q == S_CHECK) begin
      keep_q <= !taken;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_keep_q <= keep_q;
      out_x_q    <= x_q;
      out_y_q    <= y_q;
      out_fe_q   <= fe_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign keep_o          = out_keep_q;
  assign out_x_o         = out_x_q;
  assign out_y_o         = out_y_q;
  assign out_frame_end_o = out_fe_q;

`ifndef SYNTHESIS
  // Divider only reports back while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVX || state_q == S_DIVY))
    else $error("divider finished outside a divide state");

  // Tag wrap sends the block into a sweep with the tag restarted
  a_wrap_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && wrap) |=> (state_q == S_CLEAR && epoch_q == EPOCH_ONE))
    else $error("tag wrap did not start a sweep");

  // A sweep ends only after the last cell has been cleared
  a_sweep_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_CLEAR && state_q != S_CLEAR) |-> ($past(clr_q) == LAST_CELL))
    else $error("sweep left early");

  // The frame tag never takes the cleared value
  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (epoch_q != '0))
    else $error("frame tag equals cleared tag");
`endif

endmodule
